// File: rtl/ipt_pkg.sv
package ipt_pkg;

  // address family codes
  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SMALL  = 2'd1;
  localparam logic [1:0] ST_FAMILY = 2'd2;

  // smallest buffer the caller may offer
  localparam logic [7:0] V4_MIN_ROOM = 8'd16;
  localparam logic [7:0] V6_MIN_ROOM = 8'd46;

  // classified address, as handed from front to back
  typedef struct packed {
    logic [1:0]             status;
    logic                   is_v6;
    logic [0:3][2:0][3:0]   bcd;     // per octet: hundreds, tens, ones
    logic [0:7][3:0][3:0]   grp;     // IPv6 groups, group 0 first
    logic                   squeeze; // a zero run is written as "::"
    logic [2:0]             sq_grp;  // first group of that run
    logic [3:0]             rs_grp;  // group after the run, 8 if none
  } ipt_desc_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ERR,
    B_V4_DIG,
    B_V4_DOT,
    B_V6_DIG,
    B_V6_SEP,
    B_V6_CC,
    B_V6_C
  } ipt_state_e;

endpackage

// File: rtl/ipt_front.sv
module ipt_front import ipt_pkg::*; (
  input  logic [1:0]  req_type_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  buffer_size_i,
  output ipt_desc_t   desc_o
);

  // shift-and-add-3, 8 steps on a byte
  function automatic logic [11:0] to_bcd(logic [7:0] v);
    logic [11:0] b;
    b = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[3:0] >= 4'd5) b[3:0] = b[3:0] + 4'd3;
      if (b[7:4] >= 4'd5) b[7:4] = b[7:4] + 4'd3;
      b = {b[10:0], v[i]};
    end
    return b;
  endfunction

  logic [7:0] zero_grp;
  logic       found;
  logic [2:0] sq_grp;
  logic [3:0] rs_grp;
  logic [1:0] status;

  always_comb begin
    desc_o     = '0;
    desc_o.grp = {addr_high_i, addr_low_i};
    for (int i = 0; i < 4; i++) begin
      desc_o.bcd[i] = to_bcd(addr_low_i[24-8*i +: 8]);
    end
    for (int g = 0; g < 8; g++) begin
      zero_grp[g] = (desc_o.grp[g] == '0);
    end

    // first run of three zero groups starting at 0..5
    found  = 1'b0;
    sq_grp = '0;
    for (int g = 5; g >= 0; g--) begin
      if (zero_grp[g] && zero_grp[g+1] && zero_grp[g+2]) begin
        found  = 1'b1;
        sq_grp = 3'(g);
      end
    end
    // first nonzero group past the run
    rs_grp = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (k >= int'(sq_grp) + 3 && !zero_grp[k]) rs_grp = 4'(k);
    end

    case (req_type_i)
      FAM_V4:  status = (buffer_size_i < V4_MIN_ROOM) ? ST_SMALL : ST_OK;
      FAM_V6:  status = (buffer_size_i < V6_MIN_ROOM) ? ST_SMALL : ST_OK;
      default: status = ST_FAMILY;
    endcase

    desc_o.status  = status;
    desc_o.is_v6   = (req_type_i == FAM_V6);
    desc_o.squeeze = found;
    desc_o.sq_grp  = sq_grp;
    desc_o.rs_grp  = rs_grp;
  end

endmodule

// File: rtl/ipt_queue.sv
module ipt_queue import ipt_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ipt_desc_t push_desc_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output ipt_desc_t head_desc_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ipt_desc_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign valid_o     = (cnt_q != '0);
  assign head_desc_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_desc_i;
  end

endmodule

// File: rtl/ipt_back.sv
module ipt_back import ipt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  ipt_desc_t  q_desc_i,
  output logic       q_pop_o,
  output logic       strobe_o,
  output logic [7:0] text_char_o,
  output logic       last_char_o,
  output logic [1:0] status_o
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h57; // 'a' - 10
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  function automatic logic [1:0] lead_hex(logic [3:0][3:0] v);
    if (v[3] != '0)      return 2'd3;
    else if (v[2] != '0) return 2'd2;
    else if (v[1] != '0) return 2'd1;
    else                 return 2'd0;
  endfunction

  function automatic logic [1:0] lead_dec(logic [2:0][3:0] v);
    if (v[2] != '0)      return 2'd2;
    else if (v[1] != '0) return 2'd1;
    else                 return 2'd0;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'h0, n};
    else           return CH_ALPHA + {4'h0, n};
  endfunction

  ipt_state_e st_q, st_d;
  ipt_desc_t  d_q;
  logic [2:0] grp_q, grp_d;   // IPv6 group, or IPv4 octet
  logic [1:0] cnt_q, cnt_d;   // digit within group or octet
  logic       take;
  logic [2:0] nxt_grp;
  logic [1:0] nxt_oct;

  always_comb begin
    st_d        = st_q;
    grp_d       = grp_q;
    cnt_d       = cnt_q;
    take        = 1'b0;
    strobe_o    = 1'b0;
    text_char_o = CH_NUL;
    last_char_o = 1'b0;
    status_o    = d_q.status;
    nxt_grp     = grp_q + 3'd1;
    nxt_oct     = grp_q[1:0] + 2'd1;

    case (st_q)
      B_IDLE: begin
        take = 1'b1;
      end
      B_ERR: begin
        strobe_o    = 1'b1;
        last_char_o = 1'b1;
        take        = 1'b1;
      end
      B_V4_DIG: begin
        strobe_o    = 1'b1;
        text_char_o = CH_ZERO + {4'h0, d_q.bcd[grp_q[1:0]][cnt_q]};
        if (cnt_q == 2'd0) begin
          if (grp_q[1:0] == 2'd3) begin
            last_char_o = 1'b1;
            take        = 1'b1;
          end else begin
            st_d = B_V4_DOT;
          end
        end else begin
          cnt_d = cnt_q - 2'd1;
        end
      end
      B_V4_DOT: begin
        strobe_o    = 1'b1;
        text_char_o = CH_DOT;
        grp_d       = {1'b0, nxt_oct};
        cnt_d       = lead_dec(d_q.bcd[nxt_oct]);
        st_d        = B_V4_DIG;
      end
      B_V6_DIG: begin
        strobe_o    = 1'b1;
        text_char_o = hex_char(d_q.grp[grp_q][cnt_q]);
        if (cnt_q == 2'd0) begin
          if (grp_q == 3'd7) begin
            last_char_o = 1'b1;
            take        = 1'b1;
          end else begin
            st_d = B_V6_SEP;
          end
        end else begin
          cnt_d = cnt_q - 2'd1;
        end
      end
      B_V6_SEP: begin
        strobe_o    = 1'b1;
        text_char_o = CH_COLON;
        grp_d       = nxt_grp;
        if (d_q.squeeze && d_q.sq_grp == nxt_grp) begin
          st_d = B_V6_C;
        end else begin
          st_d  = B_V6_DIG;
          cnt_d = lead_hex(d_q.grp[nxt_grp]);
        end
      end
      B_V6_CC: begin
        strobe_o    = 1'b1;
        text_char_o = CH_COLON;
        st_d        = B_V6_C;
      end
      B_V6_C: begin
        strobe_o    = 1'b1;
        text_char_o = CH_COLON;
        if (d_q.rs_grp == 4'd8) begin
          last_char_o = 1'b1;
          take        = 1'b1;
        end else begin
          grp_d = d_q.rs_grp[2:0];
          cnt_d = lead_hex(d_q.grp[d_q.rs_grp[2:0]]);
          st_d  = B_V6_DIG;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase

    // the next address is popped in the cycle the current one ends
    if (take) begin
      st_d = B_IDLE;
      if (q_valid_i) begin
        grp_d = 3'd0;
        if (q_desc_i.status != ST_OK) begin
          st_d = B_ERR;
        end else if (!q_desc_i.is_v6) begin
          st_d  = B_V4_DIG;
          cnt_d = lead_dec(q_desc_i.bcd[0]);
        end else if (q_desc_i.squeeze && q_desc_i.sq_grp == 3'd0) begin
          st_d = B_V6_CC;
        end else begin
          st_d  = B_V6_DIG;
          cnt_d = lead_hex(q_desc_i.grp[0]);
        end
      end
    end
  end

  assign q_pop_o = take && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      grp_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      grp_q <= grp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) d_q <= q_desc_i;
  end

endmodule

// File: rtl/ip_address_to_text.sv
// Address-to-text formatter.
// Command channel: start_i with req_type_i, addr_high_i, addr_low_i and
// buffer_size_i is taken at a rising edge where busy_o is low. busy_o is
// high while the descriptor queue between classifier and emitter is full.
// Result channel: strobe_o marks one character per cycle on text_char_o,
// with status_o; last_char_o flags the final word of an address. An error
// (short buffer, unknown family) is one word with text_char_o of zero.
// With the emitter idle, a command is registered in the queue and then
// in the emitter's state and descriptor registers, which drive its
// first character. Throughput: an address has 1 to 39 characters;
// the emitter is the one-character-per-cycle bottleneck and
// picks up the next queued address in the cycle its last word leaves,
// so addresses follow one another with no gap.
// The receiver has no way to stall; every word is taken on its cycle.
// Reset empties the queue and returns the emitter to idle; nothing
// issued before reset is delivered.
module ip_address_to_text import ipt_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  buffer_size_i,
  output logic        strobe_o,
  output logic [7:0]  text_char_o,
  output logic        last_char_o,
  output logic [1:0]  status_o
);

  ipt_desc_t front_desc;
  ipt_desc_t head_desc;
  logic      q_full, q_valid, q_pop;

  ipt_front u_front (
    .req_type_i    (req_type_i),
    .addr_high_i   (addr_high_i),
    .addr_low_i    (addr_low_i),
    .buffer_size_i (buffer_size_i),
    .desc_o        (front_desc)
  );

  ipt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start_i && !q_full),
    .push_desc_i (front_desc),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_desc_o (head_desc)
  );

  ipt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (head_desc),
    .q_pop_o     (q_pop),
    .strobe_o    (strobe_o),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o),
    .status_o    (status_o)
  );

  assign busy_o = q_full;

`ifndef SYNTHESIS
  // an error is a single zero word
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != ST_OK |-> last_char_o && text_char_o == 8'h00)
    else $error("error result not a single zero word");

  // characters of one address leave without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_char_o |=> strobe_o)
    else $error("gap inside an address text");

  // text words are never NUL
  a_text_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o == ST_OK |-> text_char_o != 8'h00)
    else $error("NUL character in address text");

  // non-final words only carry ok status
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_char_o |-> status_o == ST_OK)
    else $error("error status on a non-final word");
`endif

endmodule

// File: sim/tb.sv
module tb;
  import ipt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic [1:0] st;
    int         tag;
  } text_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  req_type_i;
  logic [63:0] addr_high_i;
  logic [63:0] addr_low_i;
  logic [7:0]  buffer_size_i;
  logic        strobe_o;
  logic [7:0]  text_char_o;
  logic        last_char_o;
  logic [1:0]  status_o;

  text_word_t pending_chars[$];
  int         mismatch_count = 0;
  int         addr_count = 0;
  int         idle_cycles = 0;
  bit         no_idle = 1'b0;

  ip_address_to_text dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .addr_high_i  (addr_high_i),
    .addr_low_i   (addr_low_i),
    .buffer_size_i(buffer_size_i),
    .strobe_o     (strobe_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o),
    .status_o     (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // builds the expected text of one address and queues it word by word
  function automatic void format_address(input logic [1:0] fam, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic [7:0] room,
                                         input int tag);
    logic [7:0]  txt[$];
    logic [15:0] grp[8];
    logic [7:0]  oct;
    logic [3:0]  nib;
    int          i;
    int          d;
    int          g;
    bit          squeezed;
    bit          lead;
    if (fam != FAM_V4 && fam != FAM_V6) begin
      pending_chars.push_back('{8'h00, 1'b1, ST_FAMILY, tag});
      return;
    end
    if ((fam == FAM_V4 && room < V4_MIN_ROOM) || (fam == FAM_V6 && room < V6_MIN_ROOM)) begin
      pending_chars.push_back('{8'h00, 1'b1, ST_SMALL, tag});
      return;
    end
    if (fam == FAM_V4) begin
      for (i = 0; i < 4; i++) begin
        oct = lo[31 - 8 * i -: 8];
        if (oct >= 8'd100) txt.push_back("0" + oct / 8'd100);
        if (oct >= 8'd10) txt.push_back("0" + (oct / 8'd10) % 8'd10);
        txt.push_back("0" + oct % 8'd10);
        if (i != 3) txt.push_back(".");
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        grp[i]     = hi[63 - 16 * i -: 16];
        grp[i + 4] = lo[63 - 16 * i -: 16];
      end
      g = 0;
      squeezed = 1'b0;
      while (g < 8) begin
        // only the first run of 3+ zero groups collapses, longest or not
        if (!squeezed && g <= 5 && grp[g] == 16'h0 && grp[g + 1] == 16'h0 &&
            grp[g + 2] == 16'h0) begin
          squeezed = 1'b1;
          if (g == 0) txt.push_back(":");
          txt.push_back(":");
          g += 3;
          while (g < 8 && grp[g] == 16'h0) g++;
        end
        if (g < 8) begin
          lead = 1'b0;
          for (d = 3; d >= 0; d--) begin
            nib = grp[g][4 * d +: 4];
            if (lead || nib != 4'h0 || d == 0) begin
              txt.push_back((nib < 4'd10) ? ("0" + 8'(nib)) : ("a" + 8'(nib) - 8'd10));
              lead = 1'b1;
            end
          end
          if (g != 7) txt.push_back(":");
          g++;
        end
      end
    end
    for (i = 0; i < txt.size(); i++)
      pending_chars.push_back('{txt[i], (i == txt.size() - 1), ST_OK, tag});
  endfunction

  // drives one address; returns at the edge where it is taken
  task automatic issue_address(input logic [1:0] fam, input logic [63:0] hi,
                               input logic [63:0] lo, input logic [7:0] room);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    req_type_i    <= fam;
    addr_high_i   <= hi;
    addr_low_i    <= lo;
    buffer_size_i <= room;
    do @(posedge clk_i); while (busy_o);
    format_address(fam, hi, lo, room, addr_count);
    addr_count++;
  endtask

  task automatic wait_text_done();
    start_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_ipv4_edges();
    issue_address(FAM_V4, {$urandom, $urandom}, {32'hffff_ffff, 32'h0000_0000}, 8'd16);
    issue_address(FAM_V4, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_ffff_ffff, 8'd255);
    issue_address(FAM_V4, 64'h0, 64'h0000_0000_090a_6364, 8'd17);
    issue_address(FAM_V4, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_0102_0304, 8'd128);
    issue_address(FAM_V4, 64'h0, 64'h0000_0000_c0a8_00fe, 8'd46);
    wait_text_done();
  endtask

  task automatic test_ipv6_edges();
    issue_address(FAM_V6, 64'h0, 64'h0, 8'd46);
    issue_address(FAM_V6, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd255);
    issue_address(FAM_V6, 64'h0, 64'h0000_0000_0000_0001, 8'd47);
    issue_address(FAM_V6, 64'h0001_0000_0000_0000, 64'h0, 8'd100);
    issue_address(FAM_V6, 64'h2001_0db8_0000_0000, 64'h0001_0000_0000_0000, 8'd46);
    issue_address(FAM_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003, 8'd46);
    issue_address(FAM_V6, 64'h0001_0000_0000_0000, 64'h0002_0000_0000_0000, 8'd46);
    issue_address(FAM_V6, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 8'd46);
    issue_address(FAM_V6, 64'h000a_00b0_0c00_d000, 64'h0001_0012_0123_1234, 8'd200);
    issue_address(FAM_V6, 64'h0001_0002_0003_0004, 64'h0005_0006_0000_0000, 8'd46);
    issue_address(FAM_V6, 64'h0001_0002_0003_0004, 64'h0005_0000_0000_0000, 8'd46);
    wait_text_done();
  endtask

  task automatic test_error_words();
    issue_address(FAM_V4, 64'h0, 64'h0000_0000_0a00_0001, 8'd15);
    issue_address(FAM_V4, 64'h0, 64'h0000_0000_0a00_0001, 8'd0);
    issue_address(FAM_V6, 64'h2001_0db8_0000_0000, 64'h1, 8'd45);
    issue_address(FAM_V6, 64'h2001_0db8_0000_0000, 64'h1, 8'd16);
    issue_address(2'd2, {$urandom, $urandom}, {$urandom, $urandom}, 8'd255);
    issue_address(2'd3, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0);
    issue_address(2'd3, 64'h0, 64'h0, 8'd46);
    wait_text_done();
  endtask

  function automatic logic [15:0] pick_group();
    case ($urandom_range(0, 7))
      0, 1, 2: return 16'h0;
      3:       return 16'($urandom_range(1, 15));
      4:       return 16'($urandom_range(16, 255));
      5:       return 16'($urandom_range(256, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_octet();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(10, 99));
      2:       return 8'($urandom_range(100, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_random_mix(input int n_addr);
    logic [63:0] hi;
    logic [63:0] lo;
    logic [1:0]  fam;
    logic [7:0]  room;
    int          i;
    int          g;
    for (i = 0; i < n_addr; i++) begin
      no_idle = ((i / 40) % 3 == 1);
      if (i == n_addr / 2) wait_text_done();
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          fam = FAM_V4;
          for (g = 0; g < 4; g++) lo[31 - 8 * g -: 8] = pick_octet();
          room = 8'($urandom_range(V4_MIN_ROOM, 255));
        end
        6, 7, 8, 9, 10, 11, 12, 13, 14: begin
          fam = FAM_V6;
          for (g = 0; g < 4; g++) begin
            hi[63 - 16 * g -: 16] = pick_group();
            lo[63 - 16 * g -: 16] = pick_group();
          end
          room = 8'($urandom_range(V6_MIN_ROOM, 255));
        end
        15: begin
          fam = FAM_V4;
          room = 8'($urandom_range(0, V4_MIN_ROOM - 1));
        end
        16: begin
          fam = FAM_V6;
          room = 8'($urandom_range(0, V6_MIN_ROOM - 1));
        end
        17, 18: begin
          fam = 2'($urandom_range(2, 3));
          room = 8'($urandom);
        end
        default: begin
          fam = FAM_V6;
          room = 8'($urandom);
        end
      endcase
      issue_address(fam, hi, lo, room);
    end
    wait_text_done();
  endtask

  // result side: one word per strobe, no backpressure possible
  always @(posedge clk_i) begin : check_words
    text_word_t want;
    if (rst_ni === 1'b1 && strobe_o === 1'b1) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("word with nothing pending: char %h last %b status %0d",
                                text_char_o, last_char_o, status_o));
      end else begin
        want = pending_chars.pop_front();
        if (text_char_o !== want.ch)
          flag_mismatch($sformatf("addr %0d text_char %h, want %h",
                                  want.tag, text_char_o, want.ch));
        if (last_char_o !== want.last)
          flag_mismatch($sformatf("addr %0d last_char %b, want %b",
                                  want.tag, last_char_o, want.last));
        if (status_o !== want.st)
          flag_mismatch($sformatf("addr %0d status %0d, want %0d",
                                  want.tag, status_o, want.st));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || strobe_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_type_i    = FAM_V4;
    addr_high_i   = 64'h0;
    addr_low_i    = 64'h0;
    buffer_size_i = 8'h0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ipv4_edges();
    test_ipv6_edges();
    test_error_words();
    test_random_mix(345);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ipt_pkg.sv
rtl/ipt_front.sv
rtl/ipt_queue.sv
rtl/ipt_back.sv
rtl/ip_address_to_text.sv
sim/tb.sv
